FILE: hdl/chts_pkg.sv
// Package for the chained hash table with time stamps.
// Holds field widths, function and status codes and the controller state type.
// No dependencies.
package chts_pkg;

    // Fixed field widths.
    localparam int KEY_W  = 63;
    localparam int DATA_W = 64;
    localparam int TIME_W = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 3;
    localparam int BC_W   = 9;
    localparam int CFG_W  = 32;

    // Remainder unit: the key is padded to a whole number of digit groups.
    localparam int MOD_BITS   = 4;
    localparam int MOD_PAD_W  = 64;
    localparam int MOD_GROUPS = MOD_PAD_W / MOD_BITS;
    localparam int MOD_CNT_W  = $clog2(MOD_GROUPS);

    // Configuration register indexes.
    localparam logic REG_BUCKET_COUNT = 1'b0;
    localparam logic REG_AGE_LIMIT    = 1'b1;

    // Function codes.
    localparam logic [FUNC_W-1:0] FN_ADD     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_GET     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TIMEOUT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_KEY   = 3'd1;
    localparam logic [STAT_W-1:0] ST_KEY_EXISTS = 3'd2;
    localparam logic [STAT_W-1:0] ST_POOL_EMPTY = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd4;

    // Controller states.
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_BKT,
        S_CHK,
        S_NODE,
        S_ALLOC,
        S_DEL2
    } ctrl_state_t;

endpackage

FILE: hdl/chts_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module chts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/chts_mod.sv
// Iterative remainder unit: key modulo a small divisor, four bits per cycle.
// Depends on chts_pkg.
module chts_mod (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [chts_pkg::KEY_W-1:0] dividend,
    input  logic [chts_pkg::BC_W-1:0]  divisor,
    output logic                      done,
    output logic [chts_pkg::BC_W-1:0]  remainder
);
    import chts_pkg::*;

    logic [MOD_PAD_W-1:0] shift_reg;
    logic [MOD_PAD_W-1:0] shift_next;
    logic [BC_W-1:0]      rem_reg;
    logic [BC_W-1:0]      rem_next;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [BC_W:0]        trial;

    // Four restoring steps on the remainder per cycle.
    always_comb
    begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        trial      = '0;
        for (int i = 0; i < MOD_BITS; i++)
        begin
            trial      = {rem_next, shift_next[MOD_PAD_W-1]};
            shift_next = {shift_next[MOD_PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
            end
            rem_next = trial[BC_W-1:0];
        end
    end

    // Group counter and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MOD_CNT_W'(MOD_GROUPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= {{(MOD_PAD_W - KEY_W){1'b0}}, dividend};
            rem_reg   <= '0;
        end
        else if (run_reg)
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/chained_hash_table_with_timestamps.sv
// Top level of the chained hash table with time stamps: controller, bucket
// head RAM, node RAM and remainder unit. Depends on chts_pkg, chts_ram, chts_mod.
//
//  Channel   Handshake          Payload
//  request   start / busy       func, key, payload, refresh, now
//  result    done (one cycle)   status, found, record, stamp, timed_out, used_count
//  config    cfg_we             cfg_index, cfg_data
//
// A request passes through the remainder unit (four key bits a cycle), then
// the bucket head read and one node RAM read per chain node visited, then
// a finishing state. Clear sweeps every bucket head empty. After reset the
// bucket heads are swept empty, with busy high. Results cannot be stalled.
module chained_hash_table_with_timestamps #(
    parameter int POOL_SIZE   = 1024,
    parameter int MAX_BUCKETS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [chts_pkg::FUNC_W-1:0]   func,
    input  logic [chts_pkg::KEY_W-1:0]    key,
    input  logic [chts_pkg::DATA_W-1:0]   payload,
    input  logic                          refresh,
    input  logic [chts_pkg::TIME_W-1:0]   now,
    output logic                          done,
    output logic [chts_pkg::STAT_W-1:0]   status,
    output logic                          found,
    output logic [chts_pkg::DATA_W-1:0]   record,
    output logic [chts_pkg::TIME_W-1:0]   stamp,
    output logic                          timed_out,
    output logic [$clog2(POOL_SIZE+1)-1:0] used_count,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [chts_pkg::CFG_W-1:0]    cfg_data
);
    import chts_pkg::*;

    localparam int NW     = $clog2(POOL_SIZE + 1);
    localparam int PIW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int BIW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int TIM_LO = NW;
    localparam int DAT_LO = NW + TIME_W;
    localparam int KEY_LO = NW + TIME_W + DATA_W;
    localparam int NODE_W = NW + TIME_W + DATA_W + KEY_W;
    localparam logic [NW-1:0] NIL = NW'(POOL_SIZE);

    ctrl_state_t state_reg, state_next;

    // Request and configuration registers.
    logic [FUNC_W-1:0] func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] payload_reg;
    logic              refresh_reg;
    logic [TIME_W-1:0] now_reg;
    logic [BC_W-1:0]   bc_reg;
    logic [TIME_W-1:0] age_reg;

    // Walk and pool state.
    logic [BIW-1:0]    bucket_reg, bucket_next;
    logic [NW-1:0]     head_reg, head_next;
    logic [NW-1:0]     cur_reg, cur_next;
    logic [NW-1:0]     prev_reg, prev_next;
    logic [NODE_W-1:0] prev_word_reg, prev_word_next;
    logic [NODE_W-1:0] cur_word_reg, cur_word_next;
    logic [NW-1:0]     free_reg, free_next;
    logic [NW-1:0]     fill_reg, fill_next;
    logic [NW-1:0]     used_reg, used_next;
    logic [BIW-1:0]    clr_reg, clr_next;

    // Result staging.
    logic              emit;
    logic [STAT_W-1:0] res_status;
    logic              res_found;
    logic [DATA_W-1:0] res_record;
    logic [TIME_W-1:0] res_stamp;
    logic              res_timed_out;
    logic              done_reg;
    logic [STAT_W-1:0] status_reg;
    logic              found_reg;
    logic [DATA_W-1:0] record_reg;
    logic [TIME_W-1:0] stamp_reg;
    logic              timed_out_reg;
    logic [NW-1:0]     used_out_reg;

    // Memory ports.
    logic              bkt_we;
    logic [BIW-1:0]    bkt_waddr;
    logic [NW-1:0]     bkt_wdata;
    logic [BIW-1:0]    bkt_raddr;
    logic [NW-1:0]     bkt_rdata;
    logic              node_we;
    logic [PIW-1:0]    node_waddr;
    logic [NODE_W-1:0] node_wdata;
    logic [PIW-1:0]    node_raddr;
    logic [NODE_W-1:0] node_rdata;

    // Remainder unit ports and helpers.
    logic              mod_start;
    logic              mod_done;
    logic [BC_W-1:0]   mod_rem;
    logic [BC_W-1:0]   divisor;
    logic              do_alloc;
    logic [KEY_W-1:0]  nd_key;
    logic [DATA_W-1:0] nd_data;
    logic [TIME_W-1:0] nd_time;
    logic [NW-1:0]     nd_next;
    logic              accept;

    assign accept  = start && (state_reg == S_IDLE);
    assign nd_key  = node_rdata[KEY_LO +: KEY_W];
    assign nd_data = node_rdata[DAT_LO +: DATA_W];
    assign nd_time = node_rdata[TIM_LO +: TIME_W];
    assign nd_next = node_rdata[NW-1:0];

    // Effective bucket count: zero means one, large values saturate.
    always_comb
    begin
        if (bc_reg == '0)
        begin
            divisor = BC_W'(1);
        end
        else if (int'(bc_reg) > MAX_BUCKETS)
        begin
            divisor = BC_W'(MAX_BUCKETS);
        end
        else
        begin
            divisor = bc_reg;
        end
    end

    // The remainder unit loads the key at the accepting edge, straight from the port.
    chts_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (key),
        .divisor   (divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    chts_ram #(.WIDTH(NW), .DEPTH(MAX_BUCKETS)) u_bkt_ram (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (bkt_raddr),
        .rdata (bkt_rdata)
    );

    chts_ram #(.WIDTH(NODE_W), .DEPTH(POOL_SIZE)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Next state, memory accesses and result values.
    always_comb
    begin
        state_next     = state_reg;
        bucket_next    = bucket_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_word_next = prev_word_reg;
        cur_word_next  = cur_word_reg;
        free_next      = free_reg;
        fill_next      = fill_reg;
        used_next      = used_reg;
        clr_next       = clr_reg;
        emit           = 1'b0;
        res_status     = ST_OK;
        res_found      = 1'b0;
        res_record     = '0;
        res_stamp      = '0;
        res_timed_out  = 1'b0;
        bkt_we         = 1'b0;
        bkt_waddr      = bucket_reg;
        bkt_wdata      = NIL;
        bkt_raddr      = bucket_reg;
        node_we        = 1'b0;
        node_waddr     = cur_reg[PIW-1:0];
        node_wdata     = node_rdata;
        node_raddr     = cur_reg[PIW-1:0];
        mod_start      = 1'b0;
        do_alloc       = 1'b0;

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                // Sweep every bucket head to empty.
                bkt_we    = 1'b1;
                bkt_waddr = clr_reg;
                bkt_wdata = NIL;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == BIW'(MAX_BUCKETS - 1))
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                    emit       = (state_reg == S_CLEAR);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        FN_CLEAR:
                        begin
                            clr_next   = '0;
                            free_next  = '0;
                            fill_next  = '0;
                            used_next  = '0;
                            state_next = S_CLEAR;
                        end
                        FN_ADD, FN_GET, FN_DELETE, FN_TIMEOUT:
                        begin
                            if ((func == FN_ADD) && (key == '0))
                            begin
                                emit       = 1'b1;
                                res_status = ST_ZERO_KEY;
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
                mod_start = (state_next == S_DIV);
            end

            S_DIV:
            begin
                if (mod_done)
                begin
                    bucket_next = BIW'(mod_rem);
                    bkt_raddr   = BIW'(mod_rem);
                    state_next  = S_BKT;
                end
            end

            S_BKT:
            begin
                head_next  = bkt_rdata;
                cur_next   = bkt_rdata;
                prev_next  = NIL;
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (cur_reg == NIL)
                begin
                    // Key is not in the chain.
                    case (func_reg)
                        FN_ADD:
                        begin
                            if (free_reg == NIL)
                            begin
                                emit       = 1'b1;
                                res_status = ST_POOL_EMPTY;
                                state_next = S_IDLE;
                            end
                            else if (free_reg == fill_reg)
                            begin
                                // Never-used node: its successor is the next index.
                                free_next = fill_reg + 1'b1;
                                fill_next = fill_reg + 1'b1;
                                do_alloc  = 1'b1;
                            end
                            else
                            begin
                                node_raddr = free_reg[PIW-1:0];
                                state_next = S_ALLOC;
                            end
                        end
                        FN_TIMEOUT:
                        begin
                            emit          = 1'b1;
                            res_status    = ST_NOT_FOUND;
                            res_timed_out = 1'b1;
                            state_next    = S_IDLE;
                        end
                        default:
                        begin
                            emit       = 1'b1;
                            res_status = ST_NOT_FOUND;
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    node_raddr = cur_reg[PIW-1:0];
                    state_next = S_NODE;
                end
            end

            S_NODE:
            begin
                if (nd_key == key_reg)
                begin
                    state_next = S_IDLE;
                    case (func_reg)
                        FN_ADD:
                        begin
                            emit       = 1'b1;
                            res_status = ST_KEY_EXISTS;
                            res_found  = 1'b1;
                            res_stamp  = nd_time;
                        end
                        FN_GET:
                        begin
                            // Optional stamp refresh, written back in place.
                            node_we    = refresh_reg;
                            node_waddr = cur_reg[PIW-1:0];
                            node_wdata = {node_rdata[NODE_W-1:DAT_LO], now_reg,
                                          node_rdata[NW-1:0]};
                            emit       = 1'b1;
                            res_found  = 1'b1;
                            res_record = nd_data;
                            res_stamp  = refresh_reg ? now_reg : nd_time;
                        end
                        FN_DELETE:
                        begin
                            // Unlink from predecessor or from the bucket head.
                            if (prev_reg != NIL)
                            begin
                                node_we    = 1'b1;
                                node_waddr = prev_reg[PIW-1:0];
                                node_wdata = {prev_word_reg[NODE_W-1:NW], nd_next};
                            end
                            else
                            begin
                                bkt_we    = 1'b1;
                                bkt_waddr = bucket_reg;
                                bkt_wdata = nd_next;
                            end
                            cur_word_next = node_rdata;
                            state_next    = S_DEL2;
                        end
                        default:
                        begin
                            emit          = 1'b1;
                            res_found     = 1'b1;
                            res_stamp     = nd_time;
                            res_timed_out = (now_reg > nd_time) &&
                                            ((now_reg - nd_time) > age_reg);
                        end
                    endcase
                end
                else
                begin
                    prev_next      = cur_reg;
                    prev_word_next = node_rdata;
                    cur_next       = nd_next;
                    state_next     = S_CHK;
                end
            end

            S_ALLOC:
            begin
                free_next = nd_next;
                do_alloc  = 1'b1;
            end

            S_DEL2:
            begin
                // Push the freed node onto the free list.
                node_we    = 1'b1;
                node_waddr = cur_reg[PIW-1:0];
                node_wdata = {cur_word_reg[NODE_W-1:NW], free_reg};
                free_next  = cur_reg;
                if (used_reg != '0)
                begin
                    used_next = used_reg - 1'b1;
                end
                emit       = 1'b1;
                res_found  = 1'b1;
                res_stamp  = cur_word_reg[TIM_LO +: TIME_W];
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // New node at the head of its chain.
        if (do_alloc)
        begin
            node_we    = 1'b1;
            node_waddr = free_reg[PIW-1:0];
            node_wdata = {key_reg, payload_reg, now_reg, head_reg};
            bkt_we     = 1'b1;
            bkt_waddr  = bucket_reg;
            bkt_wdata  = free_reg;
            used_next  = used_reg + 1'b1;
            emit       = 1'b1;
            res_stamp  = now_reg;
            state_next = S_IDLE;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            clr_reg   <= '0;
            free_reg  <= '0;
            fill_reg  <= '0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
            bc_reg    <= BC_W'(256);
            age_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
            fill_reg  <= fill_next;
            used_reg  <= used_next;
            done_reg  <= emit;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BUCKET_COUNT: bc_reg  <= cfg_data[BC_W-1:0];
                    REG_AGE_LIMIT:    age_reg <= cfg_data[TIME_W-1:0];
                    default:          age_reg <= age_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= func;
            key_reg     <= key;
            payload_reg <= payload;
            refresh_reg <= refresh;
            now_reg     <= now;
        end
        bucket_reg    <= bucket_next;
        head_reg      <= head_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        prev_word_reg <= prev_word_next;
        cur_word_reg  <= cur_word_next;
        if (emit)
        begin
            status_reg    <= res_status;
            found_reg     <= res_found;
            record_reg    <= res_record;
            stamp_reg     <= res_stamp;
            timed_out_reg <= res_timed_out;
            used_out_reg  <= used_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign record     = record_reg;
    assign stamp      = stamp_reg;
    assign timed_out  = timed_out_reg;
    assign used_count = used_out_reg;

endmodule
